FILE: hdl/dsd_pkg.sv
// ---------------------------------------------------------------------------
// dsd_pkg: shared types and constants for the DLE/STX/ETX deframer
// Control symbols, event codes, result and counter structs, CRC-16 step.
// ---------------------------------------------------------------------------
package dsd_pkg;

  localparam logic [7:0]  SYM_DLE   = 8'h10;
  localparam logic [7:0]  SYM_STX   = 8'h02;
  localparam logic [7:0]  SYM_ETX   = 8'h03;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_RESET = 16'hFFFF;
  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_GOOD   = 3'd1,
    EV_CRCERR = 3'd2,
    EV_OVF    = 3'd3,
    EV_EXC    = 3'd4
  } ev_code_t;

  // one result from the parser
  typedef struct packed {
    logic       valid;
    ev_code_t   code;
    logic [7:0] data;
    logic [7:0] len;
  } res_t;

  typedef struct packed {
    logic [31:0] good;
    logic [31:0] crcerr;
    logic [31:0] ovf;
    logic [31:0] exc;
  } cnt_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/dsd_in_if.sv
// ---------------------------------------------------------------------------
// dsd_in_if: received byte channel
// Valid/ready handshake carrying one serial byte per word.
// ---------------------------------------------------------------------------
interface dsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/dsd_out_if.sv
// ---------------------------------------------------------------------------
// dsd_out_if: deframer result channel
// Valid/ready handshake carrying event, payload byte, length and counters.
// ---------------------------------------------------------------------------
interface dsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  frame_length;
  logic [31:0] good_frames;
  logic [31:0] crc_errors;
  logic [31:0] overflows;
  logic [31:0] exceptions;

  modport source (output valid, output event_res, output data_byte, output frame_length,
                  output good_frames, output crc_errors, output overflows,
                  output exceptions, input ready);
  modport sink   (input valid, input event_res, input data_byte, input frame_length,
                  input good_frames, input crc_errors, input overflows,
                  input exceptions, output ready);
endinterface

FILE: hdl/dsd_parser.sv
// ---------------------------------------------------------------------------
// dsd_parser: frame hunt, unstuffing, delay line and CRC check
// Updates the frame state on each accepted byte and forms its result.
// ---------------------------------------------------------------------------
module dsd_parser #(
  parameter int MAX_FRAME = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  output dsd_pkg::res_t res
);
  import dsd_pkg::*;

  localparam int SCW = $clog2(MAX_FRAME);
  localparam int LW  = (SCW > 8) ? SCW : 8;

  logic            in_frame_r, in_frame_nxt;
  logic            esc_r, esc_nxt;
  logic [7:0]      held0_r, held0_nxt;
  logic [7:0]      held1_r, held1_nxt;
  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic [SCW-1:0]  stk_r, stk_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     crc_start_r;
  logic [LW-1:0]   len_w;

  assign len_w = LW'(stk_r) - LW'(2);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    stk_nxt      = stk_r;
    crc_nxt      = crc_r;
    res          = '{valid: 1'b0, code: EV_DATA, data: 8'h00, len: 8'h00};

    if (!in_frame_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (rx_byte == SYM_STX) begin
          in_frame_nxt = 1'b1;
          held_cnt_nxt = 2'd0;
          stk_nxt      = '0;
          crc_nxt      = crc_start_r;
        end
      end else begin
        esc_nxt = (rx_byte == SYM_DLE);
      end
    end else if (!esc_r && rx_byte == SYM_DLE) begin
      esc_nxt = 1'b1;
    end else if (!esc_r || rx_byte == SYM_DLE) begin
      // plain or unstuffed byte goes onto the stack
      esc_nxt = 1'b0;
      if (stk_r == SCW'(MAX_FRAME - 1)) begin
        in_frame_nxt = 1'b0;
        held_cnt_nxt = 2'd0;
        stk_nxt      = '0;
        res.valid    = 1'b1;
        res.code     = EV_OVF;
      end else begin
        stk_nxt = stk_r + SCW'(1);
        if (held_cnt_r != 2'd2) begin
          if (held_cnt_r[0]) begin
            held1_nxt = rx_byte;
          end else begin
            held0_nxt = rx_byte;
          end
          held_cnt_nxt = held_cnt_r + 2'd1;
        end else begin
          // advance the delay line and emit the oldest byte
          held0_nxt = held1_r;
          held1_nxt = rx_byte;
          crc_nxt   = crc16_byte(crc_r, held0_r);
          res.valid = 1'b1;
          res.code  = EV_DATA;
          res.data  = held0_r;
        end
      end
    end else begin
      esc_nxt      = 1'b0;
      in_frame_nxt = 1'b0;
      held_cnt_nxt = 2'd0;
      stk_nxt      = '0;
      res.valid    = 1'b1;
      if (rx_byte == SYM_ETX) begin
        if (held_cnt_r == 2'd2 && {held1_r, held0_r} == crc_r) begin
          res.code = EV_GOOD;
          res.len  = len_w[7:0];
        end else begin
          res.code = EV_CRCERR;
        end
      end else begin
        res.code = EV_EXC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      held0_r     <= 8'h00;
      held1_r     <= 8'h00;
      held_cnt_r  <= 2'd0;
      stk_r       <= '0;
      crc_r       <= CRC_RESET;
      crc_start_r <= CRC_RESET;
    end else begin
      if (cfg_we) begin
        crc_start_r <= cfg_data;
      end
      if (fire) begin
        in_frame_r <= in_frame_nxt;
        esc_r      <= esc_nxt;
        held0_r    <= held0_nxt;
        held1_r    <= held1_nxt;
        held_cnt_r <= held_cnt_nxt;
        stk_r      <= stk_nxt;
        crc_r      <= crc_nxt;
      end
    end
  end

endmodule

FILE: hdl/dsd_counters.sv
// ---------------------------------------------------------------------------
// dsd_counters: saturating outcome counters
// Bumps the counter of each frame outcome; exposes the updated values.
// ---------------------------------------------------------------------------
module dsd_counters (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  dsd_pkg::res_t res,
  output dsd_pkg::cnt_t cnt_nxt
);
  import dsd_pkg::*;

  cnt_t cnt_r;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic hit);
    return (hit && v != CNT_MAX) ? v + 32'd1 : v;
  endfunction

  always_comb begin
    cnt_nxt.good   = sat_inc(cnt_r.good,   res.valid && res.code == EV_GOOD);
    cnt_nxt.crcerr = sat_inc(cnt_r.crcerr, res.valid && res.code == EV_CRCERR);
    cnt_nxt.ovf    = sat_inc(cnt_r.ovf,    res.valid && res.code == EV_OVF);
    cnt_nxt.exc    = sat_inc(cnt_r.exc,    res.valid && res.code == EV_EXC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/dsd_out_stage.sv
// ---------------------------------------------------------------------------
// dsd_out_stage: result register
// Holds one result word until taken; refills in the cycle it is taken.
// ---------------------------------------------------------------------------
module dsd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  dsd_pkg::res_t res,
  input  dsd_pkg::cnt_t cnt,
  output logic          in_ready,
  dsd_out_if.source     out_ch
);
  import dsd_pkg::*;

  logic       valid_r;
  logic [2:0] ev_r;
  logic [7:0] data_r;
  logic [7:0] len_r;
  cnt_t       cnt_r;

  assign in_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      ev_r   <= res.code;
      data_r <= res.data;
      len_r  <= res.len;
      cnt_r  <= cnt;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_res    = ev_r;
  assign out_ch.data_byte    = data_r;
  assign out_ch.frame_length = len_r;
  assign out_ch.good_frames  = cnt_r.good;
  assign out_ch.crc_errors   = cnt_r.crcerr;
  assign out_ch.overflows    = cnt_r.ovf;
  assign out_ch.exceptions   = cnt_r.exc;

endmodule

FILE: hdl/dle_stx_etx_deframer_crc16.sv
// ---------------------------------------------------------------------------
// dle_stx_etx_deframer_crc16: DLE/STX/ETX deframer with CRC-16 check
// Unstuffs framed bytes, strips the trailing CRC and reports frame outcomes.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    rx_byte
//  out_ch   out  valid/ready    event, byte, length, four outcome counters
//  cfg      in   cfg_we         crc_start (16 bit)
//
//  One byte is accepted per cycle; the frame state and CRC are updated in
//  the accepting cycle, and its result is loaded into the result register
//  with them. in_ch.ready is low only while a result waits and out_ch.ready is
//  low. Reset (rst_n low, synchronous) clears all frame state and counters
//  and loads crc_start with 0xFFFF; no clearing pass is needed.
// ---------------------------------------------------------------------------
module dle_stx_etx_deframer_crc16 #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  dsd_in_if.sink      in_ch,
  dsd_out_if.source   out_ch
);
  import dsd_pkg::*;

  logic fire;
  logic ready;
  res_t res;
  cnt_t cnt_nxt;

  assign in_ch.ready = ready;
  assign fire        = in_ch.valid && ready;

  dsd_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .rx_byte  (in_ch.rx_byte),
    .res      (res)
  );

  dsd_counters u_counters (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .res     (res),
    .cnt_nxt (cnt_nxt)
  );

  dsd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .cnt      (cnt_nxt),
    .in_ready (ready),
    .out_ch   (out_ch)
  );

endmodule

FILE: tb/dle_stx_etx_deframer_crc16_test.sv
// ---------------------------------------------------------------------------
// dle_stx_etx_deframer_crc16_test: self-checking bench for the deframer
// Drives a short directed byte table, then random framed traffic over
// several crc_start settings. A behavioural deframer predicts every result
// word, which is checked field by field as it leaves the block.
// ---------------------------------------------------------------------------
module dle_stx_etx_deframer_crc16_test;
  import dsd_pkg::*;

  localparam int FRAME_LIMIT    = 256;
  localparam int IDLE_PCT       = 12;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 300;
  localparam int N_PHASES       = 5;
  localparam int N_ROWS         = 26;
  localparam int NO_FORCED_DLE  = -1;

  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_LIT, CHK_PRED} chk_t;
  typedef enum logic [2:0] {FR_CLEAN, FR_BADCRC, FR_ABORT, FR_TRUNC, FR_RUNT} frame_flaw_t;

  typedef struct packed {
    logic [7:0] b;
    byte_src_t  src;
    logic       crc_init;
    logic       crc_acc;
    chk_t       chk;
    ev_code_t   ev;
    logic [7:0] data;
    logic [7:0] len;
  } dir_row_t;

  typedef struct packed {
    ev_code_t   ev;
    logic [7:0] data;
    logic [7:0] len;
    cnt_t       tally;
  } deframe_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;

  dsd_in_if  in_if();
  dsd_out_if out_if();

  dle_stx_etx_deframer_crc16 #(.MAX_FRAME(FRAME_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // predictor state
  logic        dp_in_frame = 1'b0;
  logic        dp_esc      = 1'b0;
  logic [7:0]  dp_held [2] = '{8'h00, 8'h00};
  int          dp_held_n   = 0;
  int          dp_stacked  = 0;
  logic [15:0] dp_crc      = CRC_RESET;
  logic [15:0] pred_start  = CRC_RESET;
  cnt_t        tally       = '0;

  deframe_res_t pending_results[$];
  int           fail_count   = 0;
  int           items_sent   = 0;
  int           quiet_cycles = 0;
  bit           calm         = 1'b0;
  bit           stall_req    = 1'b0;

  // expectation override for the word on offer
  chk_t       row_chk  = CHK_PRED;
  ev_code_t   row_ev   = EV_DATA;
  logic [7:0] row_data = 8'h00;
  logic [7:0] row_len  = 8'h00;

  dir_row_t dir_tab [N_ROWS] = '{
    // hunting: noise, DLE then other byte, DLE DLE then STX
    '{8'h00,   SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{8'hFF,   SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{8'h41,   SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_STX, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    // good frame: 00, stuffed DLE, FF, then its CRC
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_STX, SRC_LIT,    1'b1, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{8'h00,   SRC_LIT,    1'b0, 1'b1, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b1, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{8'hFF,   SRC_LIT,    1'b0, 1'b1, CHK_LIT,  EV_DATA,   8'h00,   8'd0},
    '{8'h00,   SRC_CRC_LO, 1'b0, 1'b0, CHK_LIT,  EV_DATA,   SYM_DLE, 8'd0},
    '{8'h00,   SRC_CRC_HI, 1'b0, 1'b0, CHK_LIT,  EV_DATA,   8'hFF,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_ETX, SRC_LIT,    1'b0, 1'b0, CHK_LIT,  EV_GOOD,   8'h00,   8'd3},
    // frame with a single byte is too short to carry a CRC
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_STX, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{8'h55,   SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_ETX, SRC_LIT,    1'b0, 1'b0, CHK_LIT,  EV_CRCERR, 8'h00,   8'd0},
    // DLE STX inside a frame is an exception
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_STX, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_DLE, SRC_LIT,    1'b0, 1'b0, CHK_NONE, EV_DATA,   8'h00,   8'd0},
    '{SYM_STX, SRC_LIT,    1'b0, 1'b0, CHK_LIT,  EV_EXC,    8'h00,   8'd0}
  };

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // bitwise CRC-16, feedback taken from the incoming bit, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // weighted towards the control symbols
  function automatic logic [7:0] line_byte();
    int pick;
    pick = $urandom_range(15);
    case (pick)
      0, 1:    return SYM_DLE;
      2:       return SYM_STX;
      3:       return SYM_ETX;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic drop_frame();
    dp_in_frame = 1'b0;
    dp_esc      = 1'b0;
    dp_held_n   = 0;
    dp_stacked  = 0;
  endtask

  // advance the predicted deframer by one received byte
  task automatic deframe_byte(input logic [7:0] c, output bit has, output deframe_res_t r);
    logic [7:0] outb;
    logic       ok;
    has = 1'b0;
    r   = '{ev: EV_DATA, data: 8'h00, len: 8'h00, tally: '0};
    if (!dp_in_frame) begin
      if (dp_esc) begin
        dp_esc = 1'b0;
        if (c == SYM_STX) begin
          dp_in_frame = 1'b1;
          dp_held_n   = 0;
          dp_stacked  = 0;
          dp_crc      = pred_start;
        end
      end else begin
        dp_esc = (c == SYM_DLE);
      end
    end else if (!dp_esc && c == SYM_DLE) begin
      dp_esc = 1'b1;
    end else if (!dp_esc || c == SYM_DLE) begin
      dp_esc = 1'b0;
      dp_stacked++;
      if (dp_stacked >= FRAME_LIMIT) begin
        drop_frame();
        tally.ovf = sat_inc(tally.ovf);
        has  = 1'b1;
        r.ev = EV_OVF;
      end else if (dp_held_n < 2) begin
        dp_held[dp_held_n] = c;
        dp_held_n++;
      end else begin
        outb       = dp_held[0];
        dp_held[0] = dp_held[1];
        dp_held[1] = c;
        dp_crc     = crc_step(dp_crc, outb);
        has    = 1'b1;
        r.data = outb;
      end
    end else begin
      dp_esc = 1'b0;
      has    = 1'b1;
      if (c == SYM_ETX) begin
        ok = (dp_held_n >= 2) && ({dp_held[1], dp_held[0]} == dp_crc);
        if (ok) begin
          tally.good = sat_inc(tally.good);
          r.ev  = EV_GOOD;
          r.len = 8'(dp_stacked - 2);
        end else begin
          tally.crcerr = sat_inc(tally.crcerr);
          r.ev = EV_CRCERR;
        end
      end else begin
        tally.exc = sat_inc(tally.exc);
        r.ev = EV_EXC;
      end
      drop_frame();
    end
    r.tally = tally;
  endtask

  // result check, then prediction for the word accepted at this edge
  always @(posedge clk) begin : track
    deframe_res_t want;
    deframe_res_t got;
    bit           has;
    if (rst_n) begin
      if (cfg_we) begin
        pred_start = cfg_data;
      end
      if (out_if.valid && out_if.ready) begin
        got.ev    = ev_code_t'(out_if.event_res);
        got.data  = out_if.data_byte;
        got.len   = out_if.frame_length;
        got.tally = '{out_if.good_frames, out_if.crc_errors, out_if.overflows,
                      out_if.exceptions};
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result ev=%0d byte=%h len=%0d", $time,
                   got.ev, got.data, got.len);
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            fail_count++;
            $display("%0t: mismatch expected ev=%0d byte=%h len=%0d counts=%h", $time,
                     want.ev, want.data, want.len, want.tally);
            $display("%0t:          actual ev=%0d byte=%h len=%0d counts=%h", $time,
                     got.ev, got.data, got.len, got.tally);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.rx_byte, has, want);
        if (row_chk == CHK_LIT) begin
          has       = 1'b1;
          want.ev   = row_ev;
          want.data = row_data;
          want.len  = row_len;
        end else if (row_chk == CHK_NONE) begin
          has = 1'b0;
        end
        if (has) begin
          pending_results.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one word and hold it until taken; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b, input chk_t chk, input ev_code_t ev,
                           input logic [7:0] data, input logic [7:0] len);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    row_chk  = chk;
    row_ev   = ev;
    row_data = data;
    row_len  = len;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, CHK_PRED, EV_DATA, 8'h00, 8'h00);
  endtask

  // DLE STX, stuffed body with CRC, DLE ETX; flaws break the frame
  task automatic send_frame(input int n, input frame_flaw_t flaw, input int dle_at);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] fcs;
    int          cut;
    fcs = pred_start;
    for (int i = 0; i < n; i++) begin
      b = (i == dle_at) ? SYM_DLE : line_byte();
      body.push_back(b);
      fcs = crc_step(fcs, b);
    end
    if (flaw == FR_BADCRC) begin
      fcs = fcs ^ (16'h0001 << $urandom_range(15));
    end
    if (flaw != FR_RUNT) begin
      body.push_back(fcs[7:0]);
      body.push_back(fcs[15:8]);
    end
    cut = (flaw == FR_ABORT || flaw == FR_TRUNC) ? $urandom_range(body.size()) : body.size();
    send_plain(SYM_DLE);
    send_plain(SYM_STX);
    for (int i = 0; i < cut; i++) begin
      if (body[i] == SYM_DLE) begin
        send_plain(SYM_DLE);
      end
      send_plain(body[i]);
    end
    case (flaw)
      FR_TRUNC: ;
      FR_ABORT: begin
        send_plain(SYM_DLE);
        if ($urandom_range(1) == 0) begin
          b = SYM_STX;
        end else begin
          do b = 8'($urandom_range(255)); while (b == SYM_DLE || b == SYM_ETX);
        end
        send_plain(b);
      end
      default: begin
        send_plain(SYM_DLE);
        send_plain(SYM_ETX);
      end
    endcase
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_crc_start(input logic [15:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    dir_row_t    row;
    logic [7:0]  b;
    logic [15:0] tx_fcs;
    logic [15:0] seeds [N_PHASES];
    frame_flaw_t flaw;
    int          start;
    int          pick;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = 16'h0000;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    tx_fcs        = CRC_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_ROWS; k++) begin
      row = dir_tab[k];
      b   = row.b;
      if (row.crc_init) begin
        tx_fcs = pred_start;
      end
      if (row.src == SRC_CRC_LO) begin
        b = tx_fcs[7:0];
      end else if (row.src == SRC_CRC_HI) begin
        b = tx_fcs[15:8];
      end
      // a CRC byte equal to DLE goes out stuffed
      if (row.src != SRC_LIT && b == SYM_DLE) begin
        send_byte(SYM_DLE, CHK_NONE, EV_DATA, 8'h00, 8'h00);
      end
      send_byte(b, row.chk, row.ev, row.data, row.len);
      if (row.crc_acc) begin
        tx_fcs = crc_step(tx_fcs, b);
      end
    end

    seeds = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535)), 16'h1D0F, 16'hFFFF};
    for (int p = 0; p < N_PHASES; p++) begin
      set_crc_start(seeds[p]);
      calm = (p == 2);
      if (p == 1) begin
        stall_req = 1'b1;
      end
      start = items_sent;
      case (p)
        1: send_frame(FRAME_LIMIT - 3, FR_CLEAN, NO_FORCED_DLE);  // longest good frame
        2: send_frame(FRAME_LIMIT - 2, FR_CLEAN, NO_FORCED_DLE);  // one byte too many
        3: send_frame(FRAME_LIMIT, FR_CLEAN, FRAME_LIMIT - 1);    // overflow on a stuffed DLE
        default: ;
      endcase
      while (items_sent - start < PHASE_ITEMS) begin
        repeat ($urandom_range(3)) send_plain(line_byte());
        pick = $urandom_range(99);
        if (pick < 60) begin
          flaw = FR_CLEAN;
        end else if (pick < 75) begin
          flaw = FR_BADCRC;
        end else if (pick < 83) begin
          flaw = FR_ABORT;
        end else if (pick < 90) begin
          flaw = FR_TRUNC;
        end else begin
          flaw = FR_RUNT;
        end
        if (flaw == FR_RUNT) begin
          send_frame($urandom_range(1), flaw, NO_FORCED_DLE);
        end else if ($urandom_range(9) == 0) begin
          send_frame($urandom_range(40), flaw, NO_FORCED_DLE);
        end else begin
          send_frame($urandom_range(12), flaw, NO_FORCED_DLE);
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
